// File: rtl/fbal_pkg.sv
// Shared types and codes for the first-fit block allocator.
package fbal_pkg;

	localparam int SIZE_W = 16;

	localparam logic [1:0] KIND_INIT  = 2'd0;
	localparam logic [1:0] KIND_ALLOC = 2'd1;
	localparam logic [1:0] KIND_FREE  = 2'd2;
	localparam logic [1:0] KIND_DONE  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOFIT    = 3'd1;
	localparam logic [2:0] ST_BADREQ   = 3'd2;
	localparam logic [2:0] ST_TOOSMALL = 3'd3;
	localparam logic [2:0] ST_NOPOOL   = 3'd4;

	typedef struct packed {
		logic [15:0] payload_offset;
		logic [2:0]  status;
	} result_t;

endpackage

// File: rtl/fbal_table.sv
// Block table memory: one write port, one registered read port.
module fbal_table #(
	parameter int DEPTH = 128,
	parameter int DW    = 33
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DW-1:0]            rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DW-1:0]            wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/fbal_seq.sv
// Sequencer: first-fit scan, entry shifting and merging over the block table.
module fbal_seq #(
	parameter int HEADER_BYTES = 32,
	parameter int MAX_BLOCKS   = 128,
	parameter int OFFSET_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [1:0]           kind,
	input  logic [15:0]          request_size,
	input  logic [15:0]          release_offset,
	input  logic [15:0]          pool_size,
	output logic                 result_valid,
	input  logic                 result_stall,
	output fbal_pkg::result_t    result
);

	localparam int SW = fbal_pkg::SIZE_W;
	localparam int OB = OFFSET_BITS;
	localparam int WB = (OB > 16) ? OB : 16;
	localparam int EW = OB + SW + 1;
	localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int PW = CW + 1;
	localparam logic [OB-1:0] HDR_O = OB'(HEADER_BYTES);
	localparam logic [SW:0]   HDR_S = (SW + 1)'(HEADER_BYTES);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_FNXT, S_SHIFT, S_FIN, S_RESP
	} state_t;

	state_t            state_q;
	logic              alloc_q, pv_q, spl_q, up_q, rdg_q, wp_q, ready_q;
	logic [15:0]       req_q, rel_q;
	logic [PW-1:0]     cnt_q, idx_q, sp_q, se_q;
	logic [1:0]        dist_q;
	logic [AW-1:0]     wa_q;
	logic [CW-1:0]     count_q;
	logic [EW-1:0]     prev_q, cur_q, new_q;
	fbal_pkg::result_t res_q;

	logic              rd_en, wr_en;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic [EW-1:0]     rd_data, wr_data;

	fbal_table #(.DEPTH(MAX_BLOCKS), .DW(EW)) u_table (
		.clk(clk), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
	);

	logic [OB-1:0]  d_start, p_start, c_start, d_pay, new_start;
	logic [SW-1:0]  d_size, p_size, c_size, new_size, init_size;
	logic           d_free, p_free;
	logic [WB-1:0]  d_pay_w;
	logic [PW-1:0]  j, cnt_p, nxt_idx;
	logic           hit, do_split, has_next, pm, nm, small_pool;
	logic [EW-1:0]  merge_word;
	logic [AW-1:0]  merge_addr;
	logic [1:0]     f_dist;
	logic [PW-1:0]  f_src;
	logic [2:0]     acc_status;
	logic           acc_scan;

	always_comb begin
		d_start    = rd_data[EW-1 -: OB];
		d_size     = rd_data[SW:1];
		d_free     = rd_data[0];
		p_start    = prev_q[EW-1 -: OB];
		p_size     = prev_q[SW:1];
		p_free     = prev_q[0];
		c_start    = cur_q[EW-1 -: OB];
		c_size     = cur_q[SW:1];
		d_pay      = d_start + HDR_O;
		d_pay_w    = WB'(d_pay);
		j          = cnt_q - PW'(1);
		cnt_p      = PW'(count_q);
		nxt_idx    = j + PW'(1);
		if (alloc_q) begin
			hit = pv_q && d_free && (d_size >= req_q);
		end else begin
			hit = pv_q && (d_pay_w == WB'(rel_q));
		end
		do_split   = ({1'b0, d_size} > ({1'b0, req_q} + HDR_S)) &&
			(count_q < CW'(MAX_BLOCKS));
		new_start  = d_pay + OB'(req_q);
		new_size   = d_size - req_q - HDR_S[SW-1:0];
		small_pool = {1'b0, pool_size} <= HDR_S;
		init_size  = pool_size - HDR_S[SW-1:0];
		has_next   = (idx_q + PW'(1)) < cnt_p;
		pm         = (idx_q != '0) && p_free;
		nm         = has_next && d_free;
		merge_addr = idx_q[AW-1:0];
		f_dist     = 2'd0;
		f_src      = idx_q + PW'(2);
		if (pm && nm) begin
			merge_word = {p_start, p_size + c_size + d_size + HDR_S[SW-1:0] +
				HDR_S[SW-1:0], 1'b1};
			merge_addr = AW'(idx_q - PW'(1));
			f_dist     = 2'd2;
		end else if (pm) begin
			merge_word = {p_start, p_size + c_size + HDR_S[SW-1:0], 1'b1};
			merge_addr = AW'(idx_q - PW'(1));
			f_dist     = 2'd1;
			f_src      = idx_q + PW'(1);
		end else if (nm) begin
			merge_word = {c_start, c_size + d_size + HDR_S[SW-1:0], 1'b1};
			f_dist     = 2'd1;
		end else begin
			merge_word = {cur_q[EW-1:1], 1'b1};
		end
		acc_status = fbal_pkg::ST_OK;
		acc_scan   = 1'b0;
		case (kind)
			fbal_pkg::KIND_INIT: begin
				if (small_pool) begin
					acc_status = fbal_pkg::ST_TOOSMALL;
				end
			end
			fbal_pkg::KIND_ALLOC: begin
				if (request_size == 16'd0) begin
					acc_status = fbal_pkg::ST_BADREQ;
				end else if (!ready_q) begin
					acc_status = fbal_pkg::ST_NOPOOL;
				end else begin
					acc_scan = 1'b1;
				end
			end
			fbal_pkg::KIND_FREE: begin
				if (!ready_q) begin
					acc_status = fbal_pkg::ST_NOPOOL;
				end else begin
					acc_scan = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cnt_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = {{OB{1'b0}}, init_size, 1'b1};
		case (state_q)
			S_IDLE: begin
				wr_en = item_valid && (kind == fbal_pkg::KIND_INIT) && !small_pool;
			end
			S_SCAN: begin
				if (hit) begin
					if (alloc_q) begin
						wr_en   = 1'b1;
						wr_addr = j[AW-1:0];
						wr_data = {d_start, do_split ? req_q : d_size, 1'b0};
					end else if (nxt_idx < cnt_p) begin
						rd_en   = 1'b1;
						rd_addr = nxt_idx[AW-1:0];
					end
				end else if (cnt_q != cnt_p) begin
					rd_en = 1'b1;
				end
			end
			S_FNXT: begin
				wr_en   = 1'b1;
				wr_addr = merge_addr;
				wr_data = merge_word;
			end
			S_SHIFT: begin
				wr_en   = wp_q;
				wr_addr = wa_q;
				wr_data = rd_data;
				rd_en   = rdg_q;
				rd_addr = sp_q[AW-1:0];
			end
			S_FIN: begin
				wr_en   = alloc_q && spl_q;
				wr_addr = AW'(idx_q + PW'(1));
				wr_data = new_q;
			end
			default: ;
		endcase
	end

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = (state_q == S_RESP);
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ready_q <= 1'b0;
			pv_q    <= 1'b0;
			rdg_q   <= 1'b0;
			wp_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						alloc_q <= (kind == fbal_pkg::KIND_ALLOC);
						req_q   <= request_size;
						rel_q   <= release_offset;
						cnt_q   <= '0;
						pv_q    <= 1'b0;
						spl_q   <= 1'b0;
						res_q   <= '{payload_offset: 16'd0, status: acc_status};
						state_q <= acc_scan ? S_SCAN : S_RESP;
						if ((kind == fbal_pkg::KIND_INIT) && !small_pool) begin
							count_q <= CW'(1);
							ready_q <= 1'b1;
						end else if (kind == fbal_pkg::KIND_DONE) begin
							count_q <= '0;
							ready_q <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						idx_q <= j;
						cur_q <= rd_data;
						if (alloc_q) begin
							res_q.payload_offset <= d_pay_w[15:0];
							spl_q <= do_split;
							new_q <= {new_start, new_size, 1'b1};
							up_q  <= 1'b1;
							sp_q  <= cnt_p - PW'(1);
							se_q  <= nxt_idx;
							rdg_q <= 1'b1;
							wp_q  <= 1'b0;
							if (!do_split) begin
								state_q <= S_RESP;
							end else if (cnt_p > nxt_idx) begin
								state_q <= S_SHIFT;
							end else begin
								state_q <= S_FIN;
							end
						end else begin
							state_q <= S_FNXT;
						end
					end else if (cnt_q == cnt_p) begin
						res_q.status <= alloc_q ? fbal_pkg::ST_NOFIT : fbal_pkg::ST_NOPOOL;
						state_q      <= S_RESP;
					end else begin
						cnt_q <= cnt_q + PW'(1);
						pv_q  <= 1'b1;
						if (pv_q) begin
							prev_q <= rd_data;
						end
					end
				end
				S_FNXT: begin
					dist_q <= f_dist;
					up_q   <= 1'b0;
					sp_q   <= f_src;
					se_q   <= cnt_p - PW'(1);
					rdg_q  <= 1'b1;
					wp_q   <= 1'b0;
					if ((f_dist != 2'd0) && (f_src < cnt_p)) begin
						state_q <= S_SHIFT;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SHIFT: begin
					if (rdg_q) begin
						wa_q <= up_q ? AW'(sp_q + PW'(1)) : AW'(sp_q - PW'(dist_q));
						wp_q <= 1'b1;
						if (sp_q == se_q) begin
							rdg_q <= 1'b0;
						end else begin
							sp_q <= up_q ? sp_q - PW'(1) : sp_q + PW'(1);
						end
					end else begin
						wp_q    <= 1'b0;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (alloc_q) begin
						count_q <= count_q + CW'(spl_q);
					end else begin
						count_q <= count_q - CW'(dist_q);
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!result_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator with coalescing.
//
// Item channel (item_valid / item_stall) takes kind, request_size and
// release_offset; a word is taken when item_valid is high and item_stall low.
// Result channel (result_valid / result_stall) gives payload_offset and status,
// exactly one result word per item, held steady while result_stall is high.
// Config channel (cfg_valid / cfg_ready) writes pool_size; always ready.
// Items are handled one at a time: item_stall stays high from acceptance until
// the result word is taken. Init, done and rejected items skip the table scan.
// Allocate and free scan the block table one entry per cycle through the single
// table read port, then shift the entries above a split or merge one per cycle.
// Reset clears the pool (no table valid), sets pool_size to 4096 and drops
// result_valid; the table memory itself is not cleared.
// A stalled result simply holds the block busy until taken.
module first_fit_block_allocator #(
	parameter int HEADER_BYTES = 32,
	parameter int MAX_BLOCKS   = 128,
	parameter int OFFSET_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  kind,
	input  logic [15:0] request_size,
	input  logic [15:0] release_offset,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] payload_offset,
	output logic [2:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic [15:0]       pool_size_q;
	fbal_pkg::result_t result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= 16'd4096;
		end else if (cfg_valid) begin
			pool_size_q <= cfg_data;
		end
	end

	fbal_seq #(
		.HEADER_BYTES(HEADER_BYTES),
		.MAX_BLOCKS(MAX_BLOCKS),
		.OFFSET_BITS(OFFSET_BITS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.kind(kind),
		.request_size(request_size),
		.release_offset(release_offset),
		.pool_size(pool_size_q),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	assign payload_offset = result.payload_offset;
	assign status         = result.status;

endmodule

// File: sim/tb_first_fit_block_allocator.sv
// Testbench for first_fit_block_allocator: checks every result word against a first-fit model.
module tb_first_fit_block_allocator;

	localparam int HDR = 32;
	localparam int NBLK = 128;
	localparam int SETTLE = 2 * NBLK + 20;
	localparam int LIMIT = 3000000;

	class alloc_scoreboard;
		int unsigned pool_len;
		int unsigned blk_start[NBLK];
		int unsigned blk_size[NBLK];
		bit blk_free[NBLK];
		int unsigned blk_count;
		bit have_pool;
		fbal_pkg::result_t due[$];
		int errors;

		function new();
			pool_len = 4096;
			blk_count = 0;
			have_pool = 0;
			errors = 0;
		endfunction

		function void remove_blk(int unsigned idx);
			for (int unsigned k = idx; k + 1 < blk_count; k++) begin
				blk_start[k] = blk_start[k + 1];
				blk_size[k] = blk_size[k + 1];
				blk_free[k] = blk_free[k + 1];
			end
			if (blk_count > 0)
				blk_count--;
		endfunction

		function void note_item(logic [1:0] k, logic [15:0] req, logic [15:0] rel);
			fbal_pkg::result_t r;
			int unsigned i;
			r.payload_offset = '0;
			r.status = fbal_pkg::ST_OK;
			case (k)
				fbal_pkg::KIND_INIT: begin
					if (pool_len <= HDR) begin
						r.status = fbal_pkg::ST_TOOSMALL;
					end else begin
						blk_start[0] = 0;
						blk_size[0] = pool_len - HDR;
						blk_free[0] = 1;
						blk_count = 1;
						have_pool = 1;
					end
				end
				fbal_pkg::KIND_ALLOC: begin
					if (req == 0) begin
						r.status = fbal_pkg::ST_BADREQ;
					end else if (!have_pool) begin
						r.status = fbal_pkg::ST_NOPOOL;
					end else begin
						r.status = fbal_pkg::ST_NOFIT;
						for (i = 0; i < blk_count; i++) begin
							if (blk_free[i] && blk_size[i] >= req) begin
								if (blk_size[i] > req + HDR && blk_count < NBLK) begin
									for (int unsigned m = blk_count; m > i + 1; m--) begin
										blk_start[m] = blk_start[m - 1];
										blk_size[m] = blk_size[m - 1];
										blk_free[m] = blk_free[m - 1];
									end
									blk_start[i + 1] = (blk_start[i] + HDR + req) & 16'hFFFF;
									blk_size[i + 1] = blk_size[i] - req - HDR;
									blk_free[i + 1] = 1;
									blk_count++;
									blk_size[i] = req;
								end
								blk_free[i] = 0;
								r.payload_offset = (blk_start[i] + HDR) & 16'hFFFF;
								r.status = fbal_pkg::ST_OK;
								break;
							end
						end
					end
				end
				fbal_pkg::KIND_FREE: begin
					if (!have_pool) begin
						r.status = fbal_pkg::ST_NOPOOL;
					end else begin
						for (i = 0; i < blk_count; i++)
							if (((blk_start[i] + HDR) & 16'hFFFF) == rel)
								break;
						if (i >= blk_count) begin
							r.status = fbal_pkg::ST_NOPOOL;
						end else begin
							blk_free[i] = 1;
							if (i > 0 && blk_free[i - 1]) begin
								blk_size[i - 1] += blk_size[i] + HDR;
								remove_blk(i);
								i--;
							end
							if (i + 1 < blk_count && blk_free[i + 1]) begin
								blk_size[i] += blk_size[i + 1] + HDR;
								remove_blk(i + 1);
							end
						end
					end
				end
				default: begin
					blk_count = 0;
					have_pool = 0;
				end
			endcase
			due.push_back(r);
		endfunction

		function void check_word(logic [15:0] off, logic [2:0] st);
			fbal_pkg::result_t e;
			if (due.size() == 0) begin
				$error("unexpected result word: payload_offset %0d status %0d", off, st);
				errors++;
				return;
			end
			e = due.pop_front();
			if (off !== e.payload_offset) begin
				$error("payload_offset: expected %0d, got %0d", e.payload_offset, off);
				errors++;
			end
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				errors++;
			end
		endfunction

		function logic [15:0] live_offset();
			if (blk_count == 0)
				return 16'($urandom);
			return 16'((blk_start[$urandom_range(blk_count - 1)] + HDR) & 16'hFFFF);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic item_valid = 0;
	logic item_stall;
	logic [1:0] kind = fbal_pkg::KIND_DONE;
	logic [15:0] request_size = '0;
	logic [15:0] release_offset = '0;
	logic result_valid;
	logic result_stall = 0;
	logic [15:0] payload_offset;
	logic [2:0] status;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	alloc_scoreboard sb = new();
	int send_idle = 0;
	int recv_idle = 0;
	int unsigned cycles = 0;

	first_fit_block_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.kind(kind), .request_size(request_size), .release_offset(release_offset),
		.result_valid(result_valid), .result_stall(result_stall),
		.payload_offset(payload_offset), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_word(payload_offset, status);
		result_stall <= ($urandom_range(99) < recv_idle);
	end

	task automatic send_word(logic [1:0] k, logic [15:0] req, logic [15:0] rel);
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 0;
			@(posedge clk);
		end
		item_valid <= 1;
		kind <= k;
		request_size <= req;
		release_offset <= rel;
		do @(posedge clk); while (item_stall);
		sb.note_item(k, req, rel);
	endtask

	task automatic drain();
		item_valid <= 0;
		@(posedge clk);
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_pool(logic [15:0] v);
		drain();
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.pool_len = v;
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_req();
		int p;
		p = $urandom_range(99);
		if (p < 70)
			return 16'($urandom_range(300, 1));
		if (p < 78)
			return '0;
		if (p < 90)
			return 16'($urandom_range(4000, 1));
		return 16'($urandom);
	endfunction

	task automatic random_items(int n, int alloc_pct);
		int p;
		for (int j = 0; j < n; j++) begin
			p = $urandom_range(99);
			if (!sb.have_pool && p < 50)
				send_word(fbal_pkg::KIND_INIT, 16'($urandom), 16'($urandom));
			else if (p < 5)
				send_word(fbal_pkg::KIND_INIT, pick_req(), 16'($urandom));
			else if (p < 8)
				send_word(fbal_pkg::KIND_DONE, 16'($urandom), 16'($urandom));
			else if (p < 8 + alloc_pct)
				send_word(fbal_pkg::KIND_ALLOC, pick_req(), 16'($urandom));
			else if ($urandom_range(9) < 8)
				send_word(fbal_pkg::KIND_FREE, 16'($urandom), sb.live_offset());
			else
				send_word(fbal_pkg::KIND_FREE, 16'($urandom), 16'($urandom));
			if (j == n / 2 && alloc_pct < 60)
				drain();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_word(fbal_pkg::KIND_DONE, '0, '0);
		send_word(fbal_pkg::KIND_ALLOC, 16'd10, '0);
		send_word(fbal_pkg::KIND_FREE, '0, 16'd32);
		send_word(fbal_pkg::KIND_ALLOC, '0, '0);
		write_pool(16'd0);
		send_word(fbal_pkg::KIND_INIT, '0, '0);
		write_pool(16'd32);
		send_word(fbal_pkg::KIND_INIT, '0, '0);
		write_pool(16'd33);
		send_word(fbal_pkg::KIND_INIT, '0, '0);
		send_word(fbal_pkg::KIND_ALLOC, 16'd2, '0);
		send_word(fbal_pkg::KIND_ALLOC, 16'd1, '0);
		send_word(fbal_pkg::KIND_FREE, '0, 16'd32);
		send_word(fbal_pkg::KIND_FREE, '0, 16'd32);
		send_word(fbal_pkg::KIND_FREE, '0, 16'd33);
		write_pool(16'hFFFF);
		send_word(fbal_pkg::KIND_INIT, '0, '0);
		send_word(fbal_pkg::KIND_ALLOC, 16'hFFFF, '0);
		send_word(fbal_pkg::KIND_ALLOC, 16'd100, '0);
		send_word(fbal_pkg::KIND_ALLOC, 16'd200, '0);
		send_word(fbal_pkg::KIND_ALLOC, 16'd50, '0);
		send_word(fbal_pkg::KIND_FREE, '0, 16'd164);
		send_word(fbal_pkg::KIND_FREE, '0, 16'd32);
		send_word(fbal_pkg::KIND_FREE, '0, 16'd396);
		send_word(fbal_pkg::KIND_ALLOC, 16'd65503, '0);

		send_idle = 23;
		recv_idle = 64;
		random_items(150, 50);

		write_pool(16'd4096);
		send_idle = 64;
		recv_idle = 23;
		random_items(150, 50);

		write_pool(16'hFFFF);
		send_idle = 0;
		recv_idle = 0;
		send_word(fbal_pkg::KIND_INIT, '0, '0);
		for (int j = 0; j < 140; j++)
			send_word(fbal_pkg::KIND_ALLOC, 16'($urandom_range(8, 1)), '0);
		random_items(100, 60);
		write_pool(16'($urandom_range(2000, 34)));
		random_items(60, 45);

		drain();
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// File: filelist.f
rtl/fbal_pkg.sv
rtl/fbal_table.sv
rtl/fbal_seq.sv
rtl/first_fit_block_allocator.sv
sim/tb_first_fit_block_allocator.sv
